### rtl/fpha_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fit-policy heap allocator package
// Shared constants, codes, command type and datapath status structure.
// ----------------------------------------------------------------------------
package fpha_pkg;

  localparam int PAGE_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_PAGES    = 16;
  localparam int MAX_SEGMENTS = 64;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int LINK_W = IDX_W + 1;
  localparam int PG_W   = $clog2(MAX_PAGES + 1);
  localparam int SP_W   = $clog2(MAX_SEGMENTS + 1);

  localparam logic [LINK_W-1:0] NIL         = LINK_W'(MAX_SEGMENTS);
  localparam logic [15:0]       MAX_PAYLOAD = 16'(PAGE_BYTES - HEADER_BYTES);

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;

  localparam logic [1:0] FIT_BEST  = 2'd0;
  localparam logic [1:0] FIT_WORST = 2'd1;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_OOM     = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LATCH,
    CMD_RD_HEAD,
    CMD_PAGE_NEW,
    CMD_TAIL_STEP,
    CMD_FIT_STEP,
    CMD_GRANT,
    CMD_SPLIT_NEW,
    CMD_SPLIT_FIX,
    CMD_BLK_T,
    CMD_LOOK_STEP,
    CMD_RD_NEXT,
    CMD_GROW,
    CMD_MOVED,
    CMD_FREE_I,
    CMD_MERGE_A,
    CMD_MERGE_B,
    CMD_SET_OOM,
    CMD_SET_UNK,
    CMD_RD_BLK,
    CMD_CAP_OFF,
    CMD_OUT_LOAD
  } cmd_t;

  typedef struct packed {
    logic head_nil;
    logic alloc_req;
    logic op_free;
    logic op_resize;
    logic present;
    logic size_zero;
    logic size_big;
    logic is_resize;
    logic page_ok;
    logic link_end;
    logic fit_end;
    logic pick_nil;
    logic look_hit;
    logic fits_inplace;
    logic grow_ok;
    logic split_ok;
    logic blk_nil;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/fit_policy_heap_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Fit-policy heap allocator
// Best, worst or first fit allocator over an address-ordered segment table.
// ----------------------------------------------------------------------------
// One request is processed at a time; each list step uses the shared
// segment table read port.
// A finished result waits in the output register while the next request
// is accepted; a held result stalls only the load of the next one.
// Synchronous active-low reset empties the heap at once.
module fit_policy_heap_allocator_unit
  import fpha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_request_size,
  input  wire logic        in_block_present,
  input  wire logic [15:0] in_block_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_result_present,
  output logic [15:0]      out_result_offset,
  output logic [1:0]       out_status,
  output logic             out_moved,
  output logic [15:0]      out_copy_bytes,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data
);

  cmd_t    cmd;
  dp_sts_t sts;

  fpha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  fpha_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_opcode          (in_opcode),
    .in_request_size    (in_request_size),
    .in_block_present   (in_block_present),
    .in_block_offset    (in_block_offset),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_result_present (out_result_present),
    .out_result_offset  (out_result_offset),
    .out_status         (out_status),
    .out_moved          (out_moved),
    .out_copy_bytes     (out_copy_bytes)
  );

endmodule
`default_nettype wire

### rtl/fpha_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/fpha_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator controller
// Sequences list walks, page appends, splits and merges by issuing commands.
// ----------------------------------------------------------------------------
module fpha_ctrl
  import fpha_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output cmd_t         cmd,
  input  wire dp_sts_t sts
);

  typedef enum logic [20:0] {
    S_IDLE = 21'h000001,
    S_DEC  = 21'h000002,
    S_PAGE = 21'h000004,
    S_TAIL = 21'h000008,
    S_FITH = 21'h000010,
    S_FIT  = 21'h000020,
    S_FITE = 21'h000040,
    S_SPLA = 21'h000080,
    S_SPLB = 21'h000100,
    S_POST = 21'h000200,
    S_LKH  = 21'h000400,
    S_LK   = 21'h000800,
    S_FREE = 21'h001000,
    S_RZ   = 21'h002000,
    S_RZN  = 21'h004000,
    S_MGH  = 21'h008000,
    S_MGA  = 21'h010000,
    S_MGB  = 21'h020000,
    S_FIN  = 21'h040000,
    S_FINR = 21'h080000,
    S_OUT  = 21'h100000
  } state_t;

  state_t state_r, state_nxt;
  logic   retry_r, retry_nxt;
  logic   inplace_r, inplace_nxt;
  logic   split_r, split_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      retry_r   <= 1'b0;
      inplace_r <= 1'b0;
      split_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      retry_r   <= retry_nxt;
      inplace_r <= inplace_nxt;
      split_r   <= split_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    retry_nxt   = retry_r;
    inplace_nxt = inplace_r;
    split_nxt   = split_r;
    cmd         = CMD_NOP;
    in_ready    = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = CMD_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        retry_nxt   = 1'b0;
        inplace_nxt = 1'b0;
        split_nxt   = 1'b0;
        if (sts.alloc_req) begin
          if (sts.size_zero) begin
            state_nxt = S_FIN;
          end else if (sts.head_nil) begin
            state_nxt = S_PAGE;
          end else begin
            state_nxt = S_FITH;
          end
        end else if ((sts.op_free || sts.op_resize) && sts.present) begin
          state_nxt = S_LKH;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_PAGE: begin
        if (sts.page_ok) begin
          cmd       = CMD_PAGE_NEW;
          state_nxt = sts.head_nil ? S_FITH : S_TAIL;
        end else begin
          cmd       = CMD_SET_OOM;
          state_nxt = S_FIN;
        end
      end
      S_TAIL: begin
        cmd = CMD_TAIL_STEP;
        if (sts.link_end) begin
          state_nxt = S_FITH;
        end
      end
      S_FITH: begin
        cmd       = CMD_RD_HEAD;
        state_nxt = S_FIT;
      end
      S_FIT: begin
        cmd = CMD_FIT_STEP;
        if (sts.fit_end) begin
          state_nxt = S_FITE;
        end
      end
      S_FITE: begin
        if (!sts.pick_nil) begin
          cmd       = CMD_GRANT;
          state_nxt = S_SPLA;
        end else if (retry_r || sts.size_big) begin
          cmd       = CMD_SET_OOM;
          state_nxt = S_FIN;
        end else begin
          retry_nxt = 1'b1;
          state_nxt = S_PAGE;
        end
      end
      S_SPLA: begin
        if (sts.split_ok) begin
          cmd       = CMD_SPLIT_NEW;
          state_nxt = S_SPLB;
        end else begin
          state_nxt = S_POST;
        end
      end
      S_SPLB: begin
        cmd       = CMD_SPLIT_FIX;
        split_nxt = 1'b1;
        state_nxt = S_POST;
      end
      S_POST: begin
        if (inplace_r) begin
          state_nxt = split_r ? S_MGH : S_FIN;
        end else if (sts.is_resize) begin
          cmd       = CMD_MOVED;
          state_nxt = S_FREE;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_LKH: begin
        if (sts.head_nil) begin
          cmd       = CMD_SET_UNK;
          state_nxt = S_FIN;
        end else begin
          cmd       = CMD_RD_HEAD;
          state_nxt = S_LK;
        end
      end
      S_LK: begin
        cmd = CMD_LOOK_STEP;
        if (sts.look_hit) begin
          state_nxt = sts.is_resize ? S_RZ : S_FREE;
        end else if (sts.link_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FREE: begin
        cmd       = CMD_FREE_I;
        state_nxt = S_MGH;
      end
      S_RZ: begin
        if (sts.fits_inplace) begin
          cmd         = CMD_BLK_T;
          inplace_nxt = 1'b1;
          state_nxt   = S_SPLA;
        end else begin
          cmd       = CMD_RD_NEXT;
          state_nxt = S_RZN;
        end
      end
      S_RZN: begin
        if (sts.grow_ok) begin
          cmd         = CMD_GROW;
          inplace_nxt = 1'b1;
          state_nxt   = S_SPLA;
        end else begin
          state_nxt = S_FITH;
        end
      end
      S_MGH: begin
        cmd       = CMD_RD_HEAD;
        state_nxt = S_MGA;
      end
      S_MGA: begin
        cmd       = CMD_MERGE_A;
        state_nxt = sts.link_end ? S_FIN : S_MGB;
      end
      S_MGB: begin
        cmd = CMD_MERGE_B;
        if (sts.link_end) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.blk_nil) begin
          state_nxt = S_OUT;
        end else begin
          cmd       = CMD_RD_BLK;
          state_nxt = S_FINR;
        end
      end
      S_FINR: begin
        cmd       = CMD_CAP_OFF;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd       = CMD_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/fpha_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator datapath
// Segment table memories, list registers, entry pool and result register.
// ----------------------------------------------------------------------------
module fpha_dp
  import fpha_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output dp_sts_t          sts,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [15:0] in_request_size,
  input  wire logic        in_block_present,
  input  wire logic [15:0] in_block_offset,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic             out_result_present,
  output logic [15:0]      out_result_offset,
  output logic [1:0]       out_status,
  output logic             out_moved,
  output logic [15:0]      out_copy_bytes
);

  logic [1:0]          fit_mode_r;
  logic [1:0]          op_r;
  logic [15:0]         s_r;
  logic                present_r;
  logic [15:0]         off_r;
  logic [LINK_W-1:0]   head_r;
  logic [SP_W-1:0]     spare_r;
  logic [PG_W-1:0]     pages_r;
  logic [MAX_SEGMENTS-1:0] busy_r;
  logic [LINK_W-1:0]   cur_r;
  logic [LINK_W-1:0]   pick_r;
  logic [15:0]         pick_len_r;
  logic [15:0]         pick_start_r;
  logic [LINK_W-1:0]   pick_link_r;
  logic [IDX_W-1:0]    t_idx_r;
  logic [15:0]         t_start_r;
  logic [15:0]         t_len_r;
  logic                t_taken_r;
  logic [LINK_W-1:0]   t_link_r;
  logic [IDX_W-1:0]    i_r;
  logic [15:0]         orig_r;
  logic [IDX_W-1:0]    k_r;
  logic [LINK_W-1:0]   blk_r;
  logic [1:0]          stat_r;
  logic                moved_r;
  logic [15:0]         copy_r;
  logic [15:0]         res_off_r;
  logic                out_valid_r;

  logic [15:0]       rd_start;
  logic [15:0]       rd_len;
  logic [0:0]        rd_taken;
  logic [LINK_W-1:0] rd_link;
  logic [IDX_W-1:0]  raddr;
  logic [IDX_W-1:0]  waddr;
  logic              we_start, we_len, we_taken, we_link;
  logic [15:0]       wd_start, wd_len;
  logic [0:0]        wd_taken;
  logic [LINK_W-1:0] wd_link;

  logic [IDX_W-1:0]  free_idx;
  logic              cand, better, first_mode, merge_now;
  logic [15:0]       merge_len, grow_len, page_base;
  logic [17:0]       grow_sum;
  logic              out_load;

  fpha_ram #(.WIDTH(16), .DEPTH(MAX_SEGMENTS)) u_start (
    .clk(clk), .we(we_start), .waddr(waddr), .wdata(wd_start),
    .raddr(raddr), .rdata(rd_start)
  );
  fpha_ram #(.WIDTH(16), .DEPTH(MAX_SEGMENTS)) u_len (
    .clk(clk), .we(we_len), .waddr(waddr), .wdata(wd_len),
    .raddr(raddr), .rdata(rd_len)
  );
  fpha_ram #(.WIDTH(1), .DEPTH(MAX_SEGMENTS)) u_taken (
    .clk(clk), .we(we_taken), .waddr(waddr), .wdata(wd_taken),
    .raddr(raddr), .rdata(rd_taken)
  );
  fpha_ram #(.WIDTH(LINK_W), .DEPTH(MAX_SEGMENTS)) u_link (
    .clk(clk), .we(we_link), .waddr(waddr), .wdata(wd_link),
    .raddr(raddr), .rdata(rd_link)
  );

  always_comb begin
    free_idx = '0;
    for (int j = MAX_SEGMENTS - 1; j >= 0; j--) begin
      if (!busy_r[j]) begin
        free_idx = IDX_W'(j);
      end
    end
  end

  assign cand       = !rd_taken[0] && (rd_len >= s_r);
  assign first_mode = (fit_mode_r != FIT_BEST) && (fit_mode_r != FIT_WORST);

  always_comb begin
    case (fit_mode_r)
      FIT_BEST:  better = (pick_r == NIL) || (rd_len < pick_len_r);
      FIT_WORST: better = (pick_r == NIL) || (rd_len > pick_len_r);
      default:   better = (pick_r == NIL);
    endcase
  end

  assign merge_now = !t_taken_r && !rd_taken[0];
  assign merge_len = 16'(32'(t_len_r) + 32'(rd_len) + HEADER_BYTES);
  assign grow_sum  = 18'(orig_r) + 18'(rd_len) + 18'(HEADER_BYTES);
  assign grow_len  = grow_sum[15:0];
  assign page_base = 16'(32'(pages_r) * PAGE_BYTES);
  assign out_load  = (cmd == CMD_OUT_LOAD);

  always_comb begin
    sts.head_nil     = (head_r == NIL);
    sts.alloc_req    = (op_r == OP_ALLOC) || ((op_r == OP_RESIZE) && !present_r);
    sts.op_free      = (op_r == OP_FREE);
    sts.op_resize    = (op_r == OP_RESIZE);
    sts.present      = present_r;
    sts.size_zero    = (s_r == '0);
    sts.size_big     = (s_r > MAX_PAYLOAD);
    sts.is_resize    = (op_r == OP_RESIZE) && present_r && (s_r != '0);
    sts.page_ok      = (pages_r < PG_W'(MAX_PAGES)) && (spare_r != '0);
    sts.link_end     = (rd_link == NIL);
    sts.fit_end      = (rd_link == NIL) || (first_mode && cand);
    sts.pick_nil     = (pick_r == NIL);
    sts.look_hit     = (17'(rd_start) + 17'(HEADER_BYTES)) == 17'(off_r);
    sts.fits_inplace = (s_r <= orig_r);
    sts.grow_ok      = (t_link_r != NIL) && !rd_taken[0] && (grow_sum >= 18'(s_r));
    sts.split_ok     = (17'(t_len_r) > (17'(s_r) + 17'(HEADER_BYTES))) && (spare_r != '0);
    sts.blk_nil      = (blk_r == NIL);
    sts.out_free     = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd)
      CMD_RD_HEAD, CMD_PAGE_NEW: raddr = head_r[IDX_W-1:0];
      CMD_FIT_STEP, CMD_TAIL_STEP, CMD_LOOK_STEP,
      CMD_MERGE_A, CMD_MERGE_B:  raddr = rd_link[IDX_W-1:0];
      CMD_RD_NEXT:               raddr = t_link_r[IDX_W-1:0];
      CMD_RD_BLK:                raddr = blk_r[IDX_W-1:0];
      default:                   raddr = cur_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    waddr    = t_idx_r;
    we_start = 1'b0;
    we_len   = 1'b0;
    we_taken = 1'b0;
    we_link  = 1'b0;
    wd_start = page_base;
    wd_len   = s_r;
    wd_taken = 1'b0;
    wd_link  = {1'b0, k_r};
    case (cmd)
      CMD_PAGE_NEW: begin
        waddr    = free_idx;
        we_start = 1'b1;
        we_len   = 1'b1;
        we_taken = 1'b1;
        we_link  = 1'b1;
        wd_len   = MAX_PAYLOAD;
        wd_link  = NIL;
      end
      CMD_TAIL_STEP: begin
        waddr   = cur_r[IDX_W-1:0];
        we_link = (rd_link == NIL);
      end
      CMD_GRANT: begin
        waddr    = pick_r[IDX_W-1:0];
        we_taken = 1'b1;
        wd_taken = 1'b1;
      end
      CMD_SPLIT_NEW: begin
        waddr    = free_idx;
        we_start = 1'b1;
        we_len   = 1'b1;
        we_taken = 1'b1;
        we_link  = 1'b1;
        wd_start = 16'(32'(t_start_r) + HEADER_BYTES + 32'(s_r));
        wd_len   = 16'(32'(t_len_r) - 32'(s_r) - HEADER_BYTES);
        wd_link  = t_link_r;
      end
      CMD_SPLIT_FIX: begin
        we_len  = 1'b1;
        we_link = 1'b1;
      end
      CMD_GROW: begin
        we_len  = 1'b1;
        we_link = 1'b1;
        wd_len  = grow_len;
        wd_link = rd_link;
      end
      CMD_FREE_I: begin
        waddr    = i_r;
        we_taken = 1'b1;
      end
      CMD_MERGE_B: begin
        we_len  = merge_now;
        we_link = merge_now;
        wd_len  = merge_len;
        wd_link = rd_link;
      end
      default: begin
        waddr = t_idx_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r  <= FIT_BEST;
      head_r      <= NIL;
      spare_r     <= SP_W'(MAX_SEGMENTS);
      pages_r     <= '0;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        fit_mode_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd)
        CMD_PAGE_NEW: begin
          busy_r[free_idx] <= 1'b1;
          spare_r          <= spare_r - 1'b1;
          if (head_r == NIL) begin
            head_r  <= {1'b0, free_idx};
            pages_r <= pages_r + 1'b1;
          end
        end
        CMD_TAIL_STEP: begin
          if (rd_link == NIL) begin
            pages_r <= pages_r + 1'b1;
          end
        end
        CMD_SPLIT_NEW: begin
          busy_r[free_idx] <= 1'b1;
          spare_r          <= spare_r - 1'b1;
        end
        CMD_GROW: begin
          busy_r[t_link_r[IDX_W-1:0]] <= 1'b0;
          spare_r                     <= spare_r + 1'b1;
        end
        CMD_MERGE_B: begin
          if (merge_now) begin
            busy_r[t_link_r[IDX_W-1:0]] <= 1'b0;
            spare_r                     <= spare_r + 1'b1;
          end
        end
        default: begin
          spare_r <= spare_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LATCH: begin
        op_r      <= in_opcode;
        s_r       <= in_request_size;
        present_r <= in_block_present;
        off_r     <= in_block_offset;
        blk_r     <= NIL;
        stat_r    <= STAT_OK;
        moved_r   <= 1'b0;
        copy_r    <= '0;
      end
      CMD_RD_HEAD: begin
        cur_r  <= head_r;
        pick_r <= NIL;
      end
      CMD_PAGE_NEW: begin
        k_r   <= free_idx;
        cur_r <= head_r;
      end
      CMD_TAIL_STEP: begin
        cur_r <= rd_link;
      end
      CMD_FIT_STEP: begin
        if (cand && better) begin
          pick_r       <= cur_r;
          pick_len_r   <= rd_len;
          pick_start_r <= rd_start;
          pick_link_r  <= rd_link;
        end
        cur_r <= rd_link;
      end
      CMD_GRANT: begin
        blk_r     <= pick_r;
        t_idx_r   <= pick_r[IDX_W-1:0];
        t_start_r <= pick_start_r;
        t_len_r   <= pick_len_r;
        t_link_r  <= pick_link_r;
      end
      CMD_SPLIT_NEW: begin
        k_r <= free_idx;
      end
      CMD_BLK_T: begin
        blk_r <= {1'b0, t_idx_r};
      end
      CMD_LOOK_STEP: begin
        if (sts.look_hit) begin
          i_r       <= cur_r[IDX_W-1:0];
          orig_r    <= rd_len;
          t_idx_r   <= cur_r[IDX_W-1:0];
          t_start_r <= rd_start;
          t_len_r   <= rd_len;
          t_link_r  <= rd_link;
        end else if (rd_link == NIL) begin
          stat_r <= STAT_UNKNOWN;
        end else begin
          cur_r <= rd_link;
        end
      end
      CMD_GROW: begin
        t_len_r  <= grow_len;
        t_link_r <= rd_link;
        blk_r    <= {1'b0, t_idx_r};
      end
      CMD_MOVED: begin
        moved_r <= 1'b1;
        copy_r  <= orig_r;
      end
      CMD_MERGE_A: begin
        t_idx_r   <= cur_r[IDX_W-1:0];
        t_len_r   <= rd_len;
        t_taken_r <= rd_taken[0];
        t_link_r  <= rd_link;
      end
      CMD_MERGE_B: begin
        if (merge_now) begin
          t_len_r  <= merge_len;
          t_link_r <= rd_link;
        end else begin
          t_idx_r   <= t_link_r[IDX_W-1:0];
          t_len_r   <= rd_len;
          t_taken_r <= rd_taken[0];
          t_link_r  <= rd_link;
        end
      end
      CMD_SET_OOM: begin
        stat_r <= STAT_OOM;
      end
      CMD_SET_UNK: begin
        stat_r <= STAT_UNKNOWN;
      end
      CMD_CAP_OFF: begin
        res_off_r <= 16'(32'(rd_start) + HEADER_BYTES);
      end
      CMD_OUT_LOAD: begin
        out_result_present <= (blk_r != NIL);
        out_result_offset  <= (blk_r != NIL) ? res_off_r : '0;
        out_status         <= stat_r;
        out_moved          <= moved_r;
        out_copy_bytes     <= copy_r;
      end
      default: begin
        cur_r <= cur_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;

  a_pool_count: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(busy_r) + int'(spare_r)) == MAX_SEGMENTS)
    else $error("entry pool count disagrees with busy bits");

  a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pages_r <= PG_W'(MAX_PAGES))
    else $error("page count beyond limit");

  a_empty_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == NIL) |-> ((pages_r == '0) && (busy_r == '0)))
    else $error("empty list while pages or entries are in use");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result transaction lost after load");

endmodule
`default_nettype wire
